// ----- sv/hash_table_separate_chaining_top_defines.svh -----
// Assertion helpers for the hash table checker.
// Both sample on clk and are off while arst_n is low.
`ifndef HASH_TABLE_SEPARATE_CHAINING_TOP_DEFINES_SVH
`define HASH_TABLE_SEPARATE_CHAINING_TOP_DEFINES_SVH

// same-cycle implication
`define HTS_ASSERT_IMP(label, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |-> (rhs)) \
		else $error(msg);

// next-cycle implication
`define HTS_ASSERT_NXT(label, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |=> (rhs)) \
		else $error(msg);

`endif

// ----- sv/hts_pkg.sv -----
`default_nettype none

package hts_pkg;

	localparam int NUM_BUCKETS_DEF = 1024;
	localparam int WAYS_DEF        = 4;

	localparam int CFG_W = 11;
	localparam int KEY_W = 31;
	localparam int VAL_W = 32;
	localparam int CNT_W = 13;
	localparam int KV_W  = KEY_W + VAL_W;   // one way: {key, value}

	localparam logic [CFG_W-1:0] BC_RESET = CFG_W'(1024);

	// remainder unit: 4 dividend bits per cycle
	localparam int DVD_W     = 32;
	localparam int DIV_BPS   = 4;
	localparam int DIV_STEPS = DVD_W / DIV_BPS;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_FIND   = 1'b1;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DUP  = 2'd1,
		ST_MISS = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_LOOK
	} state_t;

	typedef struct packed {
		status_t           status;
		logic [VAL_W-1:0]  found_value;
		logic              do_write;
	} match_res_t;

endpackage

`default_nettype wire

// ----- sv/hash_table_separate_chaining_top.sv -----
// channel | direction | handshake            | payload
// cfg     | in        | cfg_valid/cfg_ready   | bucket_count
// in      | in        | in_valid/in_ready     | op, key, value
// out     | out       | out_valid/out_ready   | status, found_value, entry_count
//
// One word at a time. From accept to the next accept, when out is free, a word passes
// through accept, the key-mod-bucket_count unit at 4 bits a cycle, a bucket read, and
// compare and write-back. The remainder unit is the longest of these steps.
// After reset a clearing pass writes NUM_BUCKETS rows of the valid memory, one a
// cycle; in_ready stays low until that pass ends. cfg is always ready.
// A finished result sits in the output register; the next word is accepted while
// it waits, and its own result holds in the compare stage until out is free.
`default_nettype none

module hash_table_separate_chaining_top #(
	parameter int NUM_BUCKETS     = hts_pkg::NUM_BUCKETS_DEF,
	parameter int WAYS_PER_BUCKET = hts_pkg::WAYS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,

	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic        [hts_pkg::CFG_W-1:0]   bucket_count,

	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               op,
	input  wire logic        [hts_pkg::KEY_W-1:0]   key,
	input  wire logic signed [hts_pkg::VAL_W-1:0]   value,

	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic             [1:0]                  status,
	output logic signed      [hts_pkg::VAL_W-1:0]   found_value,
	output logic             [hts_pkg::CNT_W-1:0]   entry_count
);

	localparam int BW       = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int ROW_KV_W = WAYS_PER_BUCKET * hts_pkg::KV_W;
	localparam logic [BW-1:0] LAST_ROW = BW'(NUM_BUCKETS - 1);

	hts_pkg::state_t state_q, state_d;

	// control
	logic [BW-1:0]                 clr_q;
	logic [hts_pkg::CFG_W-1:0]     bc_q;
	logic                          out_valid_q;
	logic [hts_pkg::CNT_W-1:0]     count_q;

	// captured word
	logic                          op_q;
	logic [hts_pkg::KEY_W-1:0]     key_q;
	logic [hts_pkg::VAL_W-1:0]     val_q;

	// result payload
	hts_pkg::status_t              status_q;
	logic [hts_pkg::VAL_W-1:0]     found_q;

	logic [hts_pkg::CFG_W-1:0]     eff_div;
	logic                          div_start;
	logic                          div_done;
	logic [hts_pkg::CFG_W-1:0]     div_rem;
	logic [BW-1:0]                 row;

	logic                          ram_re;
	logic                          load;
	logic                          vram_we;
	logic [BW-1:0]                 vram_waddr;
	logic [WAYS_PER_BUCKET-1:0]    vram_wdata;
	logic [WAYS_PER_BUCKET-1:0]    valid_row;
	logic [WAYS_PER_BUCKET-1:0]    valid_new;
	logic [ROW_KV_W-1:0]           kv_row;
	logic [ROW_KV_W-1:0]           kv_new;
	hts_pkg::match_res_t           mres;

	// bucket count in use: zero acts as one, clamp at the table size
	always_comb begin
		if (bc_q == '0) begin
			eff_div = hts_pkg::CFG_W'(1);
		end else if (32'(bc_q) > NUM_BUCKETS) begin
			eff_div = hts_pkg::CFG_W'(NUM_BUCKETS);
		end else begin
			eff_div = bc_q;
		end
	end

	hts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (key),
		.divisor  (eff_div),
		.done     (div_done),
		.rem      (div_rem)
	);

	// remainder is below the clamped count, so it fits the row index
	assign row = BW'(div_rem);

	// one row per bucket: a valid bit per way
	hts_ram #(
		.W (WAYS_PER_BUCKET),
		.D (NUM_BUCKETS)
	) u_valid_ram (
		.clk   (clk),
		.we    (vram_we),
		.waddr (vram_waddr),
		.wdata (vram_wdata),
		.re    (ram_re),
		.raddr (row),
		.rdata (valid_row)
	);

	// one row per bucket: {key, value} per way, never cleared
	hts_ram #(
		.W (ROW_KV_W),
		.D (NUM_BUCKETS)
	) u_kv_ram (
		.clk   (clk),
		.we    (load && mres.do_write),
		.waddr (row),
		.wdata (kv_new),
		.re    (ram_re),
		.raddr (row),
		.rdata (kv_row)
	);

	hts_match #(
		.WAYS (WAYS_PER_BUCKET)
	) u_match (
		.op        (op_q),
		.key       (key_q),
		.value     (val_q),
		.valid_row (valid_row),
		.kv_row    (kv_row),
		.res       (mres),
		.valid_new (valid_new),
		.kv_new    (kv_new)
	);

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		div_start  = 1'b0;
		ram_re     = 1'b0;
		load       = 1'b0;
		vram_we    = 1'b0;
		vram_waddr = row;
		vram_wdata = valid_new;
		unique case (state_q)
			hts_pkg::S_CLEAR: begin
				vram_we    = 1'b1;
				vram_waddr = clr_q;
				vram_wdata = '0;
				if (clr_q == LAST_ROW) begin
					state_d = hts_pkg::S_IDLE;
				end
			end
			hts_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					div_start = 1'b1;
					state_d   = hts_pkg::S_DIV;
				end
			end
			hts_pkg::S_DIV: begin
				if (div_done) begin
					ram_re  = 1'b1;
					state_d = hts_pkg::S_LOOK;
				end
			end
			hts_pkg::S_LOOK: begin
				// memory read data holds while the output register is full
				if (!out_valid_q || out_ready) begin
					load    = 1'b1;
					vram_we = mres.do_write;
					state_d = hts_pkg::S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hts_pkg::S_CLEAR;
			clr_q       <= '0;
			bc_q        <= hts_pkg::BC_RESET;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == hts_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_valid) begin
				bc_q <= bucket_count;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load && mres.do_write) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			op_q  <= op;
			key_q <= key;
			val_q <= value;
		end
		if (load) begin
			status_q <= mres.status;
			found_q  <= mres.found_value;
		end
	end

	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_value = found_q;
	// count moves only when a result loads, so it stays with its word
	assign entry_count = count_q;

endmodule

`default_nettype wire

// ----- sv/hts_ram.sv -----
`default_nettype none

module hts_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                                clk,
	input  wire logic                                we,
	input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  wire logic [W-1:0]                        wdata,
	input  wire logic                                re,
	input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic      [W-1:0]                        rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/hts_div.sv -----
`default_nettype none

// key mod divisor, restoring, DIV_BPS bits per cycle
module hts_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [hts_pkg::KEY_W-1:0]      dividend,
	input  wire logic [hts_pkg::CFG_W-1:0]      divisor,
	output logic                                done,
	output logic      [hts_pkg::CFG_W-1:0]      rem
);

	logic [hts_pkg::DVD_W-1:0]  dvd_q;
	logic [hts_pkg::CFG_W-1:0]  rem_q;
	logic [hts_pkg::CFG_W-1:0]  d_q;
	logic [hts_pkg::CFG_W-1:0]  rem_nx;
	logic [hts_pkg::DIV_CW-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;

	always_comb begin
		logic [hts_pkg::CFG_W:0]   t;
		logic [hts_pkg::CFG_W-1:0] r;
		r = rem_q;
		t = '0;
		for (int i = 0; i < hts_pkg::DIV_BPS; i++) begin
			t = {r, dvd_q[hts_pkg::DVD_W-1-i]};
			if (t >= {1'b0, d_q}) begin
				t = t - {1'b0, d_q};
			end
			r = t[hts_pkg::CFG_W-1:0];
		end
		rem_nx = r;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= hts_pkg::DVD_W'(dividend);
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			dvd_q <= dvd_q << hts_pkg::DIV_BPS;
			rem_q <= rem_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == hts_pkg::DIV_CW'(hts_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ----- sv/hts_match.sv -----
`default_nettype none

// compare all ways of one bucket, pick the lowest free way for an insert
module hts_match #(
	parameter int WAYS = 4
) (
	input  wire logic                               op,
	input  wire logic [hts_pkg::KEY_W-1:0]          key,
	input  wire logic [hts_pkg::VAL_W-1:0]          value,
	input  wire logic [WAYS-1:0]                    valid_row,
	input  wire logic [WAYS*hts_pkg::KV_W-1:0]      kv_row,
	output hts_pkg::match_res_t                     res,
	output logic      [WAYS-1:0]                    valid_new,
	output logic      [WAYS*hts_pkg::KV_W-1:0]      kv_new
);

	always_comb begin
		logic                      hit;
		logic                      free_taken;
		logic [hts_pkg::VAL_W-1:0] found;
		hit        = 1'b0;
		free_taken = 1'b0;
		found      = '0;
		valid_new  = valid_row;
		kv_new     = kv_row;
		for (int w = 0; w < WAYS; w++) begin
			if (!hit && valid_row[w]
					&& kv_row[w*hts_pkg::KV_W+hts_pkg::VAL_W +: hts_pkg::KEY_W] == key) begin
				hit   = 1'b1;
				found = kv_row[w*hts_pkg::KV_W +: hts_pkg::VAL_W];
			end
		end
		for (int w = 0; w < WAYS; w++) begin
			if (!free_taken && !valid_row[w]) begin
				free_taken   = 1'b1;
				valid_new[w] = 1'b1;
				kv_new[w*hts_pkg::KV_W +: hts_pkg::KV_W] = {key, value};
			end
		end

		res.found_value = '0;
		res.do_write    = 1'b0;
		if (op == hts_pkg::OP_FIND) begin
			if (hit) begin
				res.status      = hts_pkg::ST_OK;
				res.found_value = found;
			end else begin
				res.status = hts_pkg::ST_MISS;
			end
		end else if (hit) begin
			res.status = hts_pkg::ST_DUP;
		end else if (free_taken) begin
			res.status   = hts_pkg::ST_OK;
			res.do_write = 1'b1;
		end else begin
			res.status = hts_pkg::ST_FULL;
		end
	end

endmodule

`default_nettype wire

// ----- sv/hts_chk.sv -----
`default_nettype none
`include "hash_table_separate_chaining_top_defines.svh"

module hts_chk (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_valid,
	input wire logic                             in_ready,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic [1:0]                       status,
	input wire logic [hts_pkg::VAL_W-1:0]        found_value,
	input wire logic [hts_pkg::CNT_W-1:0]        entry_count
);

	`HTS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(found_value) && $stable(entry_count), "result word changed while stalled")

	`HTS_ASSERT_IMP(a_value_zero, out_valid && status != hts_pkg::ST_OK, found_value == '0, "found_value not zero on a refused or missed word")

	`HTS_ASSERT_NXT(a_one_word, in_valid && in_ready, !in_ready, "second word taken while one is in flight")

	`HTS_ASSERT_IMP(a_count_step, entry_count != $past(entry_count), out_valid && status == hts_pkg::ST_OK && entry_count == $past(entry_count) + 13'd1, "entry_count moved without a stored pair")

endmodule

bind hash_table_separate_chaining_top hts_chk u_hts_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.found_value  (found_value),
	.entry_count  (entry_count)
);

`default_nettype wire
